FILE: sv/etffa_pkg.sv
`timescale 1ns / 1ps

package etffa_pkg;

  localparam int BLK_W  = 64;
  localparam int SLOT_W = 8;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 4;

  // input tdata: action, slot, start_block, block_count (139 bits, padded to 144)
  localparam int IN_DATA_W  = 144;
  // output tdata: status, found_block, found_count, found_slot (140 bits, padded to 144)
  localparam int OUT_DATA_W = 144;

  localparam int CFG_IDX_W = 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SET       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND_FREE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FREE_SLOT = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 4'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT   = 4'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE  = 4'd2;
  localparam logic [STAT_W-1:0] ST_BELOW_AREA = 4'd3;
  localparam logic [STAT_W-1:0] ST_BEYOND     = 4'd4;
  localparam logic [STAT_W-1:0] ST_OVERLAP    = 4'd5;
  localparam logic [STAT_W-1:0] ST_SLOT_EMPTY = 4'd6;
  localparam logic [STAT_W-1:0] ST_TOO_LARGE  = 4'd7;
  localparam logic [STAT_W-1:0] ST_NO_GAP     = 4'd8;
  localparam logic [STAT_W-1:0] ST_NO_SLOT    = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_USABLE  = 1'd1;

  localparam logic [BLK_W-1:0] FIRST_USABLE_RST = 64'd34;
  localparam logic [BLK_W-1:0] LAST_USABLE_RST  = 64'd0;

endpackage

FILE: sv/extent_table_first_fit_allocator.sv
`timescale 1ns / 1ps
// One transaction at a time; every request yields exactly one result transaction.
// Remove and rejected requests answer after the prechecks; lookup reads its slot's extent;
//   first_free_slot stops at the lowest empty slot; set makes one pass, find_free 1..SLOTS+1 passes.
// Pace is set by the extent table memory: one slot read per cycle during set and find_free scans.
// Reset (rst_n low, synchronous): table emptied (valid bits cleared at once, no sweep),
//   first_usable_block=34, last_usable_block=0, output channel empty.

module extent_table_first_fit_allocator #(
  parameter int SLOTS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: action[2:0], slot[10:3], start_block[74:11], block_count[138:75], zero pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [etffa_pkg::IN_DATA_W-1:0]     in_tdata,
  // tdata: status[3:0], found_block[67:4], found_count[131:68], found_slot[139:132], pad
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [etffa_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register write port
  input  logic                                cfg_wr_en,
  input  logic [etffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [etffa_pkg::BLK_W-1:0]         cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [etffa_pkg::SLOT_W:0] SLOTS_LIM = (etffa_pkg::SLOT_W + 1)'(SLOTS);
  localparam int BW = etffa_pkg::BLK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_CALC, S_EVAL, S_SCAN, S_LK_RD, S_LK_CALC, S_RESP
  } state_t;

  // S_SCAN also serves the empty-slot search; kept apart by the action code
  state_t state_r, state_nxt;

  // request
  logic [etffa_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [etffa_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [BW-1:0]                start_r, start_nxt;
  logic [BW-1:0]                count_r, count_nxt;

  // configuration
  logic [BW-1:0] fub_r, fub_nxt;
  logic [BW-1:0] lub_r, lub_nxt;

  // precheck pipeline
  logic [BW-1:0] cm1_r, cm1_nxt;       // count - 1
  logic [BW-1:0] span_r, span_nxt;     // last_usable - first_usable
  logic          empty_r, empty_nxt;   // area empty
  logic          big_r, big_nxt;       // requested size above area size

  // current candidate range [c, end]; wrap flags an end past 2^64-1
  logic [BW-1:0] c_r, c_nxt;
  logic [BW-1:0] end_r, end_nxt;
  logic          wrap_r, wrap_nxt;
  logic          bumped_r, bumped_nxt;

  // table scan
  logic [IW-1:0] iss_r, iss_nxt;
  logic          issue_on_r, issue_on_nxt;
  logic          plive_r, plive_nxt;
  logic          plast_r, plast_nxt;
  logic          pval_r, pval_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;

  // result
  logic [etffa_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic [BW-1:0]                res_block_r, res_block_nxt;
  logic [BW-1:0]                res_count_r, res_count_nxt;
  logic [etffa_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [etffa_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [BW-1:0]                out_block_r, out_block_nxt;
  logic [BW-1:0]                out_count_r, out_count_nxt;
  logic [etffa_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;

  // extent table memory: {last, first} per slot
  logic [2*BW-1:0] tbl_mem [SLOTS];
  logic [2*BW-1:0] rd_q_r;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_ra;
  logic [2*BW-1:0] mem_wd;

  logic [IW-1:0] slot_idx;
  logic          slot_bad;
  logic [BW-1:0] q_first, q_last;
  logic [BW-1:0] base;
  logic [BW:0]   sum65;
  logic [BW:0]   bump65;
  logic          hit;
  logic          is_set, is_find;

  assign slot_idx = slot_r[IW-1:0];
  assign slot_bad = {1'b0, slot_r} >= SLOTS_LIM;
  assign q_first  = rd_q_r[BW-1:0];
  assign q_last   = rd_q_r[2*BW-1:BW];
  assign is_set   = (act_r == etffa_pkg::ACT_SET);
  assign is_find  = (act_r == etffa_pkg::ACT_FIND_FREE);
  assign base     = is_set ? start_r : fub_r;
  assign sum65    = {1'b0, base} + {1'b0, cm1_r};
  // next candidate after a colliding extent: last+1, its end last+count
  assign bump65   = {1'b0, q_last} + {1'b0, count_r};
  // a set may overwrite its own slot, so that entry is skipped
  assign hit      = pval_r && (c_r <= q_last) && (end_r >= q_first) &&
                    !(is_set && (pidx_r == slot_idx));

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_slot_r, out_count_r, out_block_r, out_status_r};

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    slot_nxt       = slot_r;
    start_nxt      = start_r;
    count_nxt      = count_r;
    fub_nxt        = fub_r;
    lub_nxt        = lub_r;
    cm1_nxt        = cm1_r;
    span_nxt       = span_r;
    empty_nxt      = empty_r;
    big_nxt        = big_r;
    c_nxt          = c_r;
    end_nxt        = end_r;
    wrap_nxt       = wrap_r;
    bumped_nxt     = bumped_r;
    iss_nxt        = iss_r;
    issue_on_nxt   = issue_on_r;
    plive_nxt      = 1'b0;
    plast_nxt      = plast_r;
    pval_nxt       = pval_r;
    pidx_nxt       = pidx_r;
    valid_nxt      = valid_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    res_count_nxt  = res_count_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_block_nxt  = out_block_r;
    out_count_nxt  = out_count_r;
    out_slot_nxt   = out_slot_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_ra         = iss_r;
    mem_wd         = {end_r, c_r};

    if (cfg_wr_en) begin
      unique case (cfg_index)
        etffa_pkg::CFG_FIRST_USABLE: fub_nxt = cfg_data;
        etffa_pkg::CFG_LAST_USABLE:  lub_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt   = in_tdata[2:0];
          slot_nxt  = in_tdata[10:3];
          start_nxt = in_tdata[74:11];
          count_nxt = in_tdata[138:75];
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        cm1_nxt   = count_r - BW'(1);
        span_nxt  = lub_r - fub_r;
        empty_nxt = lub_r < fub_r;
        state_nxt = S_CALC;
      end

      S_CALC: begin
        c_nxt     = base;
        end_nxt   = sum65[BW-1:0];
        wrap_nxt  = sum65[BW];
        big_nxt   = cm1_r > span_r;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        res_status_nxt = etffa_pkg::ST_OK;
        res_block_nxt  = '0;
        res_count_nxt  = '0;
        res_slot_nxt   = '0;
        state_nxt      = S_RESP;
        iss_nxt        = '0;
        issue_on_nxt   = 1'b1;
        bumped_nxt     = 1'b0;
        unique case (act_r)
          etffa_pkg::ACT_SET: begin
            if (slot_bad)                        res_status_nxt = etffa_pkg::ST_BAD_SLOT;
            else if (count_r == '0)              res_status_nxt = etffa_pkg::ST_ZERO_SIZE;
            else if (start_r < fub_r)            res_status_nxt = etffa_pkg::ST_BELOW_AREA;
            else if (wrap_r || (end_r > lub_r))  res_status_nxt = etffa_pkg::ST_BEYOND;
            else                                 state_nxt      = S_SCAN;
          end
          etffa_pkg::ACT_REMOVE: begin
            if (slot_bad) res_status_nxt = etffa_pkg::ST_BAD_SLOT;
            else          valid_nxt[slot_idx] = 1'b0;
          end
          etffa_pkg::ACT_LOOKUP: begin
            if (slot_bad)                res_status_nxt = etffa_pkg::ST_BAD_SLOT;
            else if (!valid_r[slot_idx]) res_status_nxt = etffa_pkg::ST_SLOT_EMPTY;
            else                         state_nxt      = S_LK_RD;
          end
          etffa_pkg::ACT_FIND_FREE: begin
            if (count_r == '0)         res_status_nxt = etffa_pkg::ST_ZERO_SIZE;
            else if (empty_r || big_r) res_status_nxt = etffa_pkg::ST_TOO_LARGE;
            else                       state_nxt      = S_SCAN;
          end
          etffa_pkg::ACT_FREE_SLOT: begin
            state_nxt = S_SCAN;
          end
          default: ;  // unknown action: ok, all fields zero
        endcase
      end

      S_SCAN: begin
        if (act_r == etffa_pkg::ACT_FREE_SLOT) begin
          // lowest empty slot straight from the valid bits
          if (!valid_r[iss_r]) begin
            res_slot_nxt = etffa_pkg::SLOT_W'(iss_r);
            state_nxt    = S_RESP;
          end else if (iss_r == LAST_IDX) begin
            res_status_nxt = etffa_pkg::ST_NO_SLOT;
            state_nxt      = S_RESP;
          end else begin
            iss_nxt = iss_r + IW'(1);
          end
        end else begin
          // issue one table read per cycle
          if (issue_on_r) begin
            mem_re    = 1'b1;
            mem_ra    = iss_r;
            plive_nxt = 1'b1;
            pval_nxt  = valid_r[iss_r];
            pidx_nxt  = iss_r;
            plast_nxt = (iss_r == LAST_IDX);
            if (iss_r == LAST_IDX) issue_on_nxt = 1'b0;
            else                   iss_nxt      = iss_r + IW'(1);
          end
          if (is_find && (wrap_r || (end_r > lub_r))) begin
            // candidate pushed past the area: no later one can fit
            res_status_nxt = etffa_pkg::ST_NO_GAP;
            state_nxt      = S_RESP;
          end else if (plive_r) begin
            if (is_set) begin
              if (hit) begin
                res_status_nxt = etffa_pkg::ST_OVERLAP;
                state_nxt      = S_RESP;
              end else if (plast_r) begin
                mem_we              = 1'b1;
                valid_nxt[slot_idx] = 1'b1;
                state_nxt           = S_RESP;
              end
            end else begin
              if (hit) begin
                c_nxt      = q_last + BW'(1);
                end_nxt    = bump65[BW-1:0];
                wrap_nxt   = bump65[BW];
                bumped_nxt = 1'b1;
              end
              if (plast_r) begin
                if (hit || bumped_r) begin
                  // candidate moved in this pass: verify it with a fresh pass
                  iss_nxt      = '0;
                  issue_on_nxt = 1'b1;
                  bumped_nxt   = 1'b0;
                end else begin
                  res_block_nxt = c_r;
                  state_nxt     = S_RESP;
                end
              end
            end
          end
        end
      end

      S_LK_RD: begin
        mem_re    = 1'b1;
        mem_ra    = slot_idx;
        state_nxt = S_LK_CALC;
      end

      S_LK_CALC: begin
        res_block_nxt = q_first;
        res_count_nxt = q_last - q_first + BW'(1);
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_block_nxt  = res_block_r;
          out_count_nxt  = res_count_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[slot_idx] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= tbl_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      fub_r       <= etffa_pkg::FIRST_USABLE_RST;
      lub_r       <= etffa_pkg::LAST_USABLE_RST;
      out_valid_r <= 1'b0;
      issue_on_r  <= 1'b0;
      plive_r     <= 1'b0;
      bumped_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      fub_r       <= fub_nxt;
      lub_r       <= lub_nxt;
      out_valid_r <= out_valid_nxt;
      issue_on_r  <= issue_on_nxt;
      plive_r     <= plive_nxt;
      bumped_r    <= bumped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    slot_r       <= slot_nxt;
    start_r      <= start_nxt;
    count_r      <= count_nxt;
    cm1_r        <= cm1_nxt;
    span_r       <= span_nxt;
    empty_r      <= empty_nxt;
    big_r        <= big_nxt;
    c_r          <= c_nxt;
    end_r        <= end_nxt;
    wrap_r       <= wrap_nxt;
    iss_r        <= iss_nxt;
    plast_r      <= plast_nxt;
    pval_r       <= pval_nxt;
    pidx_r       <= pidx_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    res_count_r  <= res_count_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_block_r  <= out_block_nxt;
    out_count_r  <= out_count_nxt;
    out_slot_r   <= out_slot_nxt;
  end

endmodule
